// ===== hw/rtl/trfs_pkg.sv =====
package trfs_pkg;

  // Fixed field widths of the block's ports.
  localparam int POINT_W  = 11;
  localparam int SAMPLE_W = 16;
  localparam int BIN_W    = 9;

  // Default largest transform length and the reset value of point_count.
  localparam int                 MAX_POINTS_DEF = 1024;
  localparam logic [POINT_W-1:0] POINT_RESET    = 11'd1024;

  // Decision the sequencer makes for the item on the input side.
  typedef struct packed {
    logic             store;      // bin goes into the half store
    logic             emit;       // item yields a result
    logic             self_pair;  // bin 0 pairs with itself
    logic             last;       // result is bin 1, the end of the frame
    logic [BIN_W-1:0] bin;        // output bin index
  } seq_ctrl_t;

endpackage

// ===== hw/rtl/two_real_fft_splitter.sv =====
// Channel   Handshake              Payload
// --------  ---------------------  ----------------------------------------------
// config    cfg_we                 cfg_data (point_count)
// bins in   bin_valid / bin_ready  bin_real, bin_imag
// results   res_valid / res_ready  bin_number, first_real, first_imag,
//                                  second_real, second_imag, frame_end
//
// One item is accepted per cycle while bin_ready is high. Its half-store read
// is registered along with the item, and the four halving adders sit between
// that middle stage and the output register, so a result passes through the
// middle stage and then the output register. Reset (rst, synchronous) sets
// point_count to 1024 and starts a new frame; the half store is not cleared.
// When the result side stalls, bin_ready drops once one more item is held in the middle stage.
module two_real_fft_splitter import trfs_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [POINT_W-1:0]         cfg_data,
  input  logic                       bin_valid,
  output logic                       bin_ready,
  input  logic signed [SAMPLE_W-1:0] bin_real,
  input  logic signed [SAMPLE_W-1:0] bin_imag,
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic [BIN_W-1:0]           bin_number,
  output logic signed [SAMPLE_W-1:0] first_real,
  output logic signed [SAMPLE_W-1:0] first_imag,
  output logic signed [SAMPLE_W-1:0] second_real,
  output logic signed [SAMPLE_W-1:0] second_imag,
  output logic                       frame_end
);

  localparam int DEPTH = MAX_POINTS / 2;
  localparam int AW    = $clog2(DEPTH);

  seq_ctrl_t       ctrl;
  logic [AW-1:0]   wr_addr;
  logic [AW-1:0]   rd_addr;
  logic            accept;
  logic            out_free;
  logic            s1_advance;

  // Middle stage: the accepted bin, waiting for its stored partner.
  logic                       s1_valid;
  logic                       s1_self;
  logic                       s1_last;
  logic [BIN_W-1:0]           s1_bin;
  logic signed [SAMPLE_W-1:0] s1_re;
  logic signed [SAMPLE_W-1:0] s1_im;

  logic [2*SAMPLE_W-1:0]      store_rdata;
  logic signed [SAMPLE_W-1:0] a_re;
  logic signed [SAMPLE_W-1:0] a_im;
  logic signed [SAMPLE_W-1:0] f_re;
  logic signed [SAMPLE_W-1:0] f_im;
  logic signed [SAMPLE_W-1:0] s_re;
  logic signed [SAMPLE_W-1:0] s_im;

  assign out_free   = !res_valid || res_ready;
  assign s1_advance = s1_valid && out_free;
  assign bin_ready  = !s1_valid || out_free;
  assign accept     = bin_valid && bin_ready;

  trfs_seq #(
    .MAX_POINTS (MAX_POINTS),
    .AW         (AW)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .accept   (accept),
    .ctrl     (ctrl),
    .wr_addr  (wr_addr),
    .rd_addr  (rd_addr)
  );

  // First-half bins are written as they arrive; the mirror is read on
  // acceptance only, so a stalled middle stage keeps its read data.
  trfs_ram #(
    .WIDTH (2 * SAMPLE_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (accept && ctrl.store),
    .waddr (wr_addr),
    .wdata ({bin_real, bin_imag}),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (store_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= ctrl.emit;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_self <= ctrl.self_pair;
      s1_last <= ctrl.last;
      s1_bin  <= ctrl.bin;
      s1_re   <= bin_real;
      s1_im   <= bin_imag;
    end
  end

  // Bin 0 pairs with itself; every other result takes the stored bin.
  assign a_re = s1_self ? s1_re : store_rdata[2*SAMPLE_W-1:SAMPLE_W];
  assign a_im = s1_self ? s1_im : store_rdata[SAMPLE_W-1:0];

  trfs_bfly u_bfly (
    .a_re      (a_re),
    .a_im      (a_im),
    .b_re      (s1_re),
    .b_im      (s1_im),
    .first_re  (f_re),
    .first_im  (f_im),
    .second_re (s_re),
    .second_im (s_im)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      bin_number  <= s1_bin;
      first_real  <= f_re;
      first_imag  <= f_im;
      second_real <= s_re;
      second_imag <= s_im;
      frame_end   <= s1_last;
    end
  end

endmodule

// ===== hw/rtl/trfs_ram.sv =====
module trfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/trfs_seq.sv =====
module trfs_seq import trfs_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int AW         = $clog2(MAX_POINTS / 2)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [POINT_W-1:0] cfg_data,
  input  logic               accept,
  output seq_ctrl_t          ctrl,
  output logic [AW-1:0]      wr_addr,
  output logic [AW-1:0]      rd_addr
);

  logic [POINT_W-1:0] point_count;
  logic [POINT_W-1:0] sample_counter;
  logic [POINT_W-1:0] sample_counter_next;
  logic [POINT_W-1:0] half;
  logic [POINT_W-1:0] k;
  logic [POINT_W-1:0] k_inc;
  logic [POINT_W-1:0] mirror;
  logic               active;

  // Odd lengths and lengths out of range swallow every item.
  assign active = !point_count[0] && (point_count >= POINT_W'(4))
                  && (32'(point_count) <= MAX_POINTS);
  assign half   = point_count >> 1;
  assign k      = (sample_counter >= point_count) ? '0 : sample_counter;
  assign k_inc  = k + POINT_W'(1);
  assign mirror = point_count - k;

  always_comb begin
    ctrl.store     = active && (k < half);
    ctrl.self_pair = (k == '0);
    ctrl.emit      = active && ((k == '0) || (k > half));
    ctrl.last      = (k > half) && (mirror == POINT_W'(1));
    ctrl.bin       = (k > half) ? mirror[BIN_W-1:0] : '0;
  end

  assign wr_addr = AW'(k);
  assign rd_addr = AW'(mirror);

  always_comb begin
    sample_counter_next = sample_counter;
    if (cfg_we) begin
      sample_counter_next = '0;
    end else if (accept && active) begin
      sample_counter_next = (k_inc >= point_count) ? '0 : k_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count    <= POINT_RESET;
      sample_counter <= '0;
    end else begin
      if (cfg_we) begin
        point_count <= cfg_data;
      end
      sample_counter <= sample_counter_next;
    end
  end

endmodule

// ===== hw/rtl/trfs_bfly.sv =====
module trfs_bfly import trfs_pkg::*; (
  input  logic signed [SAMPLE_W-1:0] a_re,
  input  logic signed [SAMPLE_W-1:0] a_im,
  input  logic signed [SAMPLE_W-1:0] b_re,
  input  logic signed [SAMPLE_W-1:0] b_im,
  output logic signed [SAMPLE_W-1:0] first_re,
  output logic signed [SAMPLE_W-1:0] first_im,
  output logic signed [SAMPLE_W-1:0] second_re,
  output logic signed [SAMPLE_W-1:0] second_im
);

  logic signed [SAMPLE_W:0] sum_re;
  logic signed [SAMPLE_W:0] dif_im;
  logic signed [SAMPLE_W:0] dif_re;
  logic signed [SAMPLE_W:0] sum_im;

  // Full-width sums, then dropping the low bit is a floor halving.
  assign sum_re = (SAMPLE_W+1)'(a_re) + (SAMPLE_W+1)'(b_re);
  assign dif_im = (SAMPLE_W+1)'(a_im) - (SAMPLE_W+1)'(b_im);
  assign dif_re = (SAMPLE_W+1)'(a_re) - (SAMPLE_W+1)'(b_re);
  assign sum_im = (SAMPLE_W+1)'(a_im) + (SAMPLE_W+1)'(b_im);

  assign first_re  = sum_re[SAMPLE_W:1];
  assign first_im  = dif_im[SAMPLE_W:1];
  assign second_re = dif_re[SAMPLE_W:1];
  assign second_im = sum_im[SAMPLE_W:1];

endmodule
